// ===== design/rtrm_pkg.sv =====
// Shared constants, register codes and sideband types for the tilt and rate block.
package rtrm_pkg;

  localparam int QW      = 16;
  localparam int RCW     = 26;
  localparam int MW      = 52;
  localparam int PW      = 56;
  localparam int ZW      = 26;
  localparam int S30W    = 31;
  localparam int SQ_NB   = 32;
  localparam int PRODW   = 49;
  localparam int RATE_GAIN = 66754;
  localparam int ONE_DEG = 65536;
  localparam int TAB_LEN = 24;

  localparam logic signed [PW-1:0] ONE40 = PW'(64'd1 << 40);

  localparam int ATAN_TAB [TAB_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum logic [7:0] {
    REG_NEUTRAL_W = 8'd0,
    REG_NEUTRAL_X = 8'd1,
    REG_NEUTRAL_Y = 8'd2,
    REG_NEUTRAL_Z = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [PW-1:0]   ys;
    logic signed [PW-1:0]   xs;
    logic signed [S30W-1:0] s30;
    logic                   hi;
    logic                   lo;
  } asin_side_t;

  typedef struct packed {
    logic [15:0] mag;
    logic        hi;
    logic        lo;
  } cord_side_t;

endpackage

// ===== design/rtrm_if.sv =====
// Channel interfaces: sample input, result output and register write port.
interface rtrm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

interface rtrm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_angle;
  logic signed [14:0] roll_angle;
  logic [15:0]        rate_magnitude;
  modport source (output valid, pitch_angle, roll_angle, rate_magnitude, input ready);
  modport sink (input valid, pitch_angle, roll_angle, rate_magnitude, output ready);
endinterface

interface rtrm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/rtrm_isqrt.sv =====
// Two-lane pipelined integer square root, one result bit per stage.
module rtrm_isqrt import rtrm_pkg::*; #(
  parameter int NB = 32,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*NB-1:0] in_rad [2],
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [NB-1:0]   out_root [2],
  output logic [SW-1:0]   out_side
);

  localparam int RW = NB + 3;
  localparam int DW = 2 * NB;

  logic [DW-1:0] rad_r   [NB][2];
  logic [RW-1:0] rem_r   [NB][2];
  logic [NB-1:0] root_r  [NB][2];
  logic [DW-1:0] rad_nxt [NB][2];
  logic [RW-1:0] rem_nxt [NB][2];
  logic [NB-1:0] root_nxt[NB][2];
  logic [SW-1:0] side_r  [NB];
  logic [NB-1:0] vld_r;

  always_comb begin
    logic [DW-1:0] rd;
    logic [RW-1:0] rs;
    logic [RW-1:0] rn;
    logic [RW-1:0] tr;
    logic [NB-1:0] ro;
    for (int k = 0; k < NB; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          rd = in_rad[l];
          rs = '0;
          ro = '0;
        end else begin
          rd = rad_r[k-1][l];
          rs = rem_r[k-1][l];
          ro = root_r[k-1][l];
        end
        rn = {rs[RW-3:0], rd[DW-1 -: 2]};
        tr = {1'b0, ro, 2'b01};
        rad_nxt[k][l] = {rd[DW-3:0], 2'b00};
        if (rn >= tr) begin
          rem_nxt[k][l]  = rn - tr;
          root_nxt[k][l] = {ro[NB-2:0], 1'b1};
        end else begin
          rem_nxt[k][l]  = rn;
          root_nxt[k][l] = {ro[NB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NB-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r[0] <= in_side;
      for (int k = 1; k < NB; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid   = vld_r[NB-1];
  assign out_root[0] = root_r[NB-1][0];
  assign out_root[1] = root_r[NB-1][1];
  assign out_side    = side_r[NB-1];

endmodule

// ===== design/rtrm_cordic.sv =====
// Two-lane pipelined CORDIC vectoring unit returning atan2 in 2^-16 degree.
module rtrm_cordic import rtrm_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [PW-1:0] in_x [2],
  input  logic signed [PW-1:0] in_y [2],
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_z [2],
  output logic [SW-1:0]        out_side
);

  localparam logic signed [ZW-1:0] Z90 = ZW'(90 * ONE_DEG);

  logic signed [PW-1:0] x_r   [STEPS+1][2];
  logic signed [PW-1:0] y_r   [STEPS+1][2];
  logic signed [ZW-1:0] z_r   [STEPS+1][2];
  logic                 zr_r  [STEPS+1][2];
  logic signed [PW-1:0] x_nxt [STEPS+1][2];
  logic signed [PW-1:0] y_nxt [STEPS+1][2];
  logic signed [ZW-1:0] z_nxt [STEPS+1][2];
  logic                 zr_nxt[STEPS+1][2];
  logic [SW-1:0]        side_r[STEPS+1];
  logic [STEPS:0]       vld_r;

  always_comb begin
    logic signed [PW-1:0] dx;
    logic signed [PW-1:0] dy;
    for (int l = 0; l < 2; l++) begin
      zr_nxt[0][l] = (in_x[l] == '0) && (in_y[l] == '0);
      if (in_x[l] < 0) begin
        if (in_y[l] >= 0) begin
          x_nxt[0][l] = in_y[l];
          y_nxt[0][l] = -in_x[l];
          z_nxt[0][l] = Z90;
        end else begin
          x_nxt[0][l] = -in_y[l];
          y_nxt[0][l] = in_x[l];
          z_nxt[0][l] = -Z90;
        end
      end else begin
        x_nxt[0][l] = in_x[l];
        y_nxt[0][l] = in_y[l];
        z_nxt[0][l] = '0;
      end
      for (int k = 1; k <= STEPS; k++) begin
        dx = y_r[k-1][l] >>> (k - 1);
        dy = x_r[k-1][l] >>> (k - 1);
        zr_nxt[k][l] = zr_r[k-1][l];
        if (y_r[k-1][l] >= 0) begin
          x_nxt[k][l] = x_r[k-1][l] + dx;
          y_nxt[k][l] = y_r[k-1][l] - dy;
          z_nxt[k][l] = z_r[k-1][l] + ZW'(ATAN_TAB[k-1]);
        end else begin
          x_nxt[k][l] = x_r[k-1][l] - dx;
          y_nxt[k][l] = y_r[k-1][l] + dy;
          z_nxt[k][l] = z_r[k-1][l] - ZW'(ATAN_TAB[k-1]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      zr_r <= zr_nxt;
      side_r[0] <= in_side;
      for (int k = 1; k <= STEPS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_z[0]  = zr_r[STEPS][0] ? '0 : z_r[STEPS][0];
  assign out_z[1]  = zr_r[STEPS][1] ? '0 : z_r[STEPS][1];
  assign out_side  = side_r[STEPS];

endmodule

// ===== design/relative_tilt_and_rate_magnitude_top.sv =====
// Top level: relative rotation, pitch/roll angles and gyro rate magnitude.
//
//  channel | dir | beat payload
//  cfg_ch  | in  | index, data (neutral quaternion w/x/y/z)
//  in_ch   | in  | quat_w..quat_z, rate_x..rate_z
//  out_ch  | out | pitch_angle, roll_angle, rate_magnitude
//
// One beat per cycle while out_ch is not stalled; the pipeline has five front stages,
// 32 square-root stages, one scaling stage, the CORDIC stages plus its
// pre-rotation stage, and the output register. The square-root pipeline sets
// the depth. Reset brings the neutral quaternion to identity and empties the
// pipeline. A stall on out_ch freezes every stage; cfg_ch is always ready.
module relative_tilt_and_rate_magnitude_top import rtrm_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input logic         clk,
  input logic         rst_n,
  rtrm_cfg_if.sink    cfg_ch,
  rtrm_in_if.sink     in_ch,
  rtrm_out_if.source  out_ch
);

  localparam int AW = ZW + 1;
  localparam logic signed [AW-1:0] HALF = AW'(1 << (15 - ANGLE_FRAC_BITS));
  localparam logic signed [AW-1:0] PLIM = AW'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [AW-1:0] RLIM = AW'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [AW-1:0] PMAX = AW'(32767);
  localparam logic signed [AW-1:0] PMIN = -AW'(32768);
  localparam logic signed [AW-1:0] RMAX = AW'(16383);
  localparam logic signed [AW-1:0] RMIN = -AW'(16384);

  logic signed [QW-1:0] nw_r, nx_r, ny_r, nz_r;
  logic                 en;
  logic [5:1]           v_r;

  logic signed [31:0]    p_r [16];
  logic signed [31:0]    g2_r [3];
  logic signed [RCW-1:0] rw2_r, rx2_r, ry2_r, rz2_r;
  logic [31:0]           ssum2_r, ssum3_r, ssum4_r, ssum5_r;
  logic signed [MW-1:0]  mwx3_r, myz3_r, mxx3_r, myy3_r, mwy3_r, mzx3_r;
  logic signed [PW-1:0]  ys4_r, xs4_r, ys5_r, xs5_r, sinp;
  logic signed [S30W-1:0] s30_4_r, s30_5_r;
  logic                  hi4_r, lo4_r, hi5_r, lo5_r;
  logic [61:0]           sq5_r;

  logic [2*SQ_NB-1:0]    sq_rad [2];
  logic [SQ_NB-1:0]      sq_root [2];
  asin_side_t            sq_side_in, sq_side_out;
  logic                  sq_valid;

  logic                  v6_r;
  logic [PRODW-1:0]      prod6_r;
  logic signed [PW-1:0]  ys6_r, xs6_r;
  logic signed [S30W-1:0] s30_6_r;
  logic [SQ_NB-1:0]      c30_6_r;
  logic                  hi6_r, lo6_r;
  logic [PRODW:0]        mag_rnd;

  logic signed [PW-1:0]  cx [2];
  logic signed [PW-1:0]  cy [2];
  logic signed [ZW-1:0]  cz [2];
  cord_side_t            cs_in, cs_out;
  logic                  c_valid;

  logic signed [AW-1:0]  pa, ra;
  logic                  out_valid_r;
  logic signed [15:0]    pitch_r;
  logic signed [14:0]    roll_r;
  logic [15:0]           mag_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nw_r <= 16'sd16384;
      nx_r <= '0;
      ny_r <= '0;
      nz_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_NEUTRAL_W: nw_r <= cfg_ch.data;
        REG_NEUTRAL_X: nx_r <= cfg_ch.data;
        REG_NEUTRAL_Y: ny_r <= cfg_ch.data;
        REG_NEUTRAL_Z: nz_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[4:1], in_ch.valid};
      v6_r        <= sq_valid;
      out_valid_r <= c_valid;
    end
  end

  always_comb begin
    sinp = (PW'(mwy3_r) - PW'(mzx3_r)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= nw_r * in_ch.quat_w;
      p_r[1]  <= nx_r * in_ch.quat_x;
      p_r[2]  <= ny_r * in_ch.quat_y;
      p_r[3]  <= nz_r * in_ch.quat_z;
      p_r[4]  <= nw_r * in_ch.quat_x;
      p_r[5]  <= nx_r * in_ch.quat_w;
      p_r[6]  <= ny_r * in_ch.quat_z;
      p_r[7]  <= nz_r * in_ch.quat_y;
      p_r[8]  <= nw_r * in_ch.quat_y;
      p_r[9]  <= nx_r * in_ch.quat_z;
      p_r[10] <= ny_r * in_ch.quat_w;
      p_r[11] <= nz_r * in_ch.quat_x;
      p_r[12] <= nw_r * in_ch.quat_z;
      p_r[13] <= nx_r * in_ch.quat_y;
      p_r[14] <= ny_r * in_ch.quat_x;
      p_r[15] <= nz_r * in_ch.quat_w;
      g2_r[0] <= in_ch.rate_x * in_ch.rate_x;
      g2_r[1] <= in_ch.rate_y * in_ch.rate_y;
      g2_r[2] <= in_ch.rate_z * in_ch.rate_z;

      rw2_r <= RCW'((34'(p_r[0]) + 34'(p_r[1]) + 34'(p_r[2]) + 34'(p_r[3])) >>> 8);
      rx2_r <= RCW'((34'(p_r[4]) - 34'(p_r[5]) - 34'(p_r[6]) + 34'(p_r[7])) >>> 8);
      ry2_r <= RCW'((34'(p_r[8]) + 34'(p_r[9]) - 34'(p_r[10]) - 34'(p_r[11])) >>> 8);
      rz2_r <= RCW'((34'(p_r[12]) - 34'(p_r[13]) + 34'(p_r[14]) - 34'(p_r[15])) >>> 8);
      ssum2_r <= 32'(unsigned'(g2_r[0])) + 32'(unsigned'(g2_r[1]))
               + 32'(unsigned'(g2_r[2]));

      mwx3_r  <= rw2_r * rx2_r;
      myz3_r  <= ry2_r * rz2_r;
      mxx3_r  <= rx2_r * rx2_r;
      myy3_r  <= ry2_r * ry2_r;
      mwy3_r  <= rw2_r * ry2_r;
      mzx3_r  <= rz2_r * rx2_r;
      ssum3_r <= ssum2_r;

      ys4_r   <= (PW'(mwx3_r) + PW'(myz3_r)) <<< 1;
      xs4_r   <= ONE40 - ((PW'(mxx3_r) + PW'(myy3_r)) <<< 1);
      hi4_r   <= sinp >= ONE40;
      lo4_r   <= sinp <= -ONE40;
      s30_4_r <= sinp[40:10];
      ssum4_r <= ssum3_r;

      sq5_r   <= 62'(s30_4_r * s30_4_r);
      ys5_r   <= ys4_r;
      xs5_r   <= xs4_r;
      s30_5_r <= s30_4_r;
      hi5_r   <= hi4_r;
      lo5_r   <= lo4_r;
      ssum5_r <= ssum4_r;
    end
  end

  assign sq_rad[0] = (64'd1 << 60) - {2'b00, sq5_r};
  assign sq_rad[1] = {ssum5_r, 32'd0};
  assign sq_side_in = '{ys: ys5_r, xs: xs5_r, s30: s30_5_r, hi: hi5_r, lo: lo5_r};

  rtrm_isqrt #(
    .NB (SQ_NB),
    .SW ($bits(asin_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[5]),
    .in_rad    (sq_rad),
    .in_side   (sq_side_in),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side_out)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      prod6_r <= {17'd0, sq_root[1]} * PRODW'(RATE_GAIN);
      c30_6_r <= sq_root[0];
      ys6_r   <= sq_side_out.ys;
      xs6_r   <= sq_side_out.xs;
      s30_6_r <= sq_side_out.s30;
      hi6_r   <= sq_side_out.hi;
      lo6_r   <= sq_side_out.lo;
    end
  end

  assign mag_rnd   = {1'b0, prod6_r} + (50'd1 << 31);
  assign cx[0]     = xs6_r;
  assign cy[0]     = ys6_r;
  assign cx[1]     = PW'(c30_6_r);
  assign cy[1]     = PW'(s30_6_r);
  assign cs_in.mag = (mag_rnd[PRODW:32] > 18'd65535) ? 16'hFFFF : mag_rnd[47:32];
  assign cs_in.hi  = hi6_r;
  assign cs_in.lo  = lo6_r;

  rtrm_cordic #(
    .STEPS (CORDIC_STEPS),
    .SW    ($bits(cord_side_t))
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_x      (cx),
    .in_y      (cy),
    .in_side   (cs_in),
    .out_valid (c_valid),
    .out_z     (cz),
    .out_side  (cs_out)
  );

  always_comb begin
    pa = (AW'(cz[0]) + HALF) >>> (16 - ANGLE_FRAC_BITS);
    if (pa > PLIM) pa = PLIM;
    if (pa < -PLIM) pa = -PLIM;
    if (pa > PMAX) pa = PMAX;
    if (pa < PMIN) pa = PMIN;
    priority if (cs_out.hi) begin
      ra = RLIM;
    end else if (cs_out.lo) begin
      ra = -RLIM;
    end else begin
      ra = (AW'(cz[1]) + HALF) >>> (16 - ANGLE_FRAC_BITS);
    end
    if (ra > RLIM) ra = RLIM;
    if (ra < -RLIM) ra = -RLIM;
    if (ra > RMAX) ra = RMAX;
    if (ra < RMIN) ra = RMIN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_r <= pa[15:0];
      roll_r  <= ra[14:0];
      mag_r   <= cs_out.mag;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pitch_angle    = pitch_r;
  assign out_ch.roll_angle     = roll_r;
  assign out_ch.rate_magnitude = mag_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[1])
    else $error("accepted beat did not enter the first stage");

  a_clamp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> !(hi4_r && lo4_r))
    else $error("asin clamp flags both set");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r) && $stable(v6_r))
    else $error("pipeline moved during stall");

endmodule

// ===== bench/tb_top.sv =====
// Tilt and rate testbench: scoreboard with its own angle predictor, stimulus and checks.
`timescale 1ns / 1ps

module tb_top;
  import rtrm_pkg::*;

  localparam int STEPS     = 16;
  localparam int FRAC      = 7;
  localparam int DRAIN     = 40 + STEPS + 14;
  localparam int WD_LIMIT  = 5000;
  localparam int N_RANDOM  = 530;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz, gx, gy, gz;
  } sample_t;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [14:0] roll;
    logic [15:0]        mag;
  } tilt_rate_t;

  class tilt_rate_scoreboard;
    tilt_rate_t expected_results[$];
    logic signed [15:0] neutral[4];
    int errors;
    int checked;

    function new();
      neutral = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] v);
      if (idx <= REG_NEUTRAL_Z) neutral[idx] = v;
    endfunction

    static function longint unsigned isqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    static function longint atan2_deg(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = 90 * ONE_DEG;
        end else begin
          x = -y; y = t; z = -90 * ONE_DEG;
        end
      end
      for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ATAN_TAB[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_TAB[i];
        end
      end
      return z;
    endfunction

    static function longint quantize(longint z, longint lim_deg, longint fmin, longint fmax);
      longint a, lim;
      a = (z + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC);
      lim = lim_deg << FRAC;
      if (a > lim) a = lim;
      if (a < -lim) a = -lim;
      if (a > fmax) a = fmax;
      if (a < fmin) a = fmin;
      return a;
    endfunction

    function tilt_rate_t predict(sample_t s);
      longint nw, nx, ny, nz, qw, qx, qy, qz, gx, gy, gz;
      longint rw, rx, ry, rz, ys, xs, sinp, s30, one40;
      longint unsigned sq, c30, ssum, root, mag;
      tilt_rate_t r;
      nw = neutral[0]; nx = neutral[1]; ny = neutral[2]; nz = neutral[3];
      qw = s.qw; qx = s.qx; qy = s.qy; qz = s.qz;
      gx = s.gx; gy = s.gy; gz = s.gz;
      one40 = longint'(1) << 40;
      rw = (nw * qw + nx * qx + ny * qy + nz * qz) >>> 8;
      rx = (nw * qx - nx * qw - ny * qz + nz * qy) >>> 8;
      ry = (nw * qy + nx * qz - ny * qw - nz * qx) >>> 8;
      rz = (nw * qz - nx * qy + ny * qx - nz * qw) >>> 8;
      ys = 2 * (rw * rx + ry * rz);
      xs = one40 - 2 * (rx * rx + ry * ry);
      r.pitch = 16'(quantize(atan2_deg(ys, xs), 180, -32768, 32767));
      sinp = 2 * (rw * ry - rz * rx);
      if (sinp >= one40) begin
        r.roll = 15'(quantize(90 * ONE_DEG, 90, -16384, 16383));
      end else if (sinp <= -one40) begin
        r.roll = 15'(quantize(-90 * ONE_DEG, 90, -16384, 16383));
      end else begin
        s30 = sinp >>> 10;
        sq = s30 * s30;
        c30 = isqrt((64'd1 << 60) - sq);
        r.roll = 15'(quantize(atan2_deg(s30, longint'(c30)), 90, -16384, 16383));
      end
      ssum = gx * gx + gy * gy + gz * gz;
      root = isqrt(ssum << 32);
      mag = (root * RATE_GAIN + (64'd1 << 31)) >> 32;
      if (mag > 65535) mag = 65535;
      r.mag = mag[15:0];
      return r;
    endfunction

    function void note_sample(sample_t s);
      expected_results.push_back(predict(s));
    endfunction

    function void check_result(logic signed [15:0] pitch, logic signed [14:0] roll,
                               logic [15:0] mag);
      tilt_rate_t e;
      checked++;
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation: pitch %0d roll %0d mag %0d",
               pitch, roll, mag);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (pitch !== e.pitch) begin
        $error("pitch_angle: expected %0d, got %0d", e.pitch, pitch);
        errors++;
      end
      if (roll !== e.roll) begin
        $error("roll_angle: expected %0d, got %0d", e.roll, roll);
        errors++;
      end
      if (mag !== e.mag) begin
        $error("rate_magnitude: expected %0d, got %0d", e.mag, mag);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  rtrm_cfg_if cfg_ch ();
  rtrm_in_if  in_ch ();
  rtrm_out_if out_ch ();

  relative_tilt_and_rate_magnitude_top #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_FRAC_BITS(FRAC)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_ch(cfg_ch.sink),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  tilt_rate_scoreboard sb;
  int  idle_cycles;
  int  samples_sent;
  int  cfg_writes;
  bit  long_hold_done;
  bit  burst_mode;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    sb = new();
    rst_n         <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.quat_w  <= '0;
    in_ch.quat_x  <= '0;
    in_ch.quat_y  <= '0;
    in_ch.quat_z  <= '0;
    in_ch.rate_x  <= '0;
    in_ch.rate_y  <= '0;
    in_ch.rate_z  <= '0;
    out_ch.ready  <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_sample(sample_t s);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.quat_w <= s.qw;
    in_ch.quat_x <= s.qx;
    in_ch.quat_y <= s.qy;
    in_ch.quat_z <= s.qz;
    in_ch.rate_x <= s.gx;
    in_ch.rate_y <= s.gy;
    in_ch.rate_z <= s.gz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s);
    samples_sent++;
    if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
  endtask

  task automatic send_fields(int qw, int qx, int qy, int qz, int gx, int gy, int gz);
    sample_t s;
    s.qw = 16'(qw); s.qx = 16'(qx); s.qy = 16'(qy); s.qz = 16'(qz);
    s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
    send_sample(s);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(cfg_reg_t'(idx), v);
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_neutral(int w, int x, int y, int z);
    settle();
    write_reg(REG_NEUTRAL_W, 16'(w));
    write_reg(REG_NEUTRAL_X, 16'(x));
    write_reg(REG_NEUTRAL_Y, 16'(y));
    write_reg(REG_NEUTRAL_Z, 16'(z));
  endtask

  task automatic random_sample();
    sample_t s;
    int span;
    span = ($urandom_range(0, 9) < 4) ? 32768 : (($urandom_range(0, 1) == 1) ? 16384 : 8192);
    s.qw = (span == 32768) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    s.qx = (span == 32768) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    s.qy = (span == 32768) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    s.qz = (span == 32768) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    s.gx = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
    s.gy = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
    s.gz = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
    send_sample(s);
  endtask

  initial begin : receiver
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && sb.checked == 120) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.pitch_angle, out_ch.roll_angle, out_ch.rate_magnitude);
    end
  end

  initial begin : stimulus
    idle_cycles = 0;
    samples_sent = 0;
    cfg_writes = 0;
    long_hold_done = 1'b0;
    burst_mode = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity neutral from reset
    send_fields(16384, 0, 0, 0, 0, 0, 0);
    send_fields(32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_fields(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_fields(0, 0, 0, 0, 1, -1, 0);
    send_fields(11586, 0, 11586, 0, 900, 0, 0);
    send_fields(11586, 0, -11586, 0, 0, 900, 0);
    send_fields(11585, 0, 11585, 0, 0, 0, 900);
    send_fields(0, 32767, 0, 0, -32768, 0, 0);
    send_fields(0, -32768, 0, 0, 0, -32768, 0);
    send_fields(11585, 11585, 0, 0, 100, 200, 300);
    send_fields(11585, -11585, 0, 0, -100, -200, -300);
    send_fields(16384, 0, 0, 16384, 32767, -32768, 32767);
    send_fields(0, 0, 0, 16384, 0, 0, 32767);
    send_fields(8192, 8192, 8192, 8192, 5, 5, 5);

    write_neutral(11585, 0, 11585, 0);
    send_fields(11585, 0, 11585, 0, 0, 0, 0);
    send_fields(16384, 0, 0, 0, 450, 450, 450);
    write_neutral(32767, 32767, 32767, 32767);
    send_fields(32767, -32768, 32767, -32768, 32767, 0, 0);
    send_fields(16384, 0, 0, 0, 0, 0, 0);
    write_neutral(-32768, -32768, -32768, -32768);
    send_fields(-32768, -32768, -32768, -32768, 0, 0, 0);
    send_fields(16384, 4096, -4096, 0, 1000, -1000, 1);
    settle();
    write_reg(8'd4, 16'h1234);
    write_reg(8'd255, 16'hFFFF);
    send_fields(16384, 0, 0, 0, 0, 0, 0);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_neutral(16384, 0, 0, 0);
        1: write_neutral($urandom_range(0, 32767) - 16384, $urandom_range(0, 16383) - 8192,
                         $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192);
        2: write_neutral($urandom, $urandom, $urandom, $urandom);
        3: write_neutral(0, 16384, 0, 0);
        default: write_neutral(16384, 0, 0, 0);
      endcase
      for (int i = 0; i < N_RANDOM / 5; i++) random_sample();
    end

    settle();
    $display("run covered %0d samples and %0d register writes, %0d results checked",
             samples_sent, cfg_writes, sb.checked);
    $display("directed extremes, clamped roll, pitch wraparound and five neutral settings");
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rtrm_pkg.sv
design/rtrm_if.sv
design/rtrm_isqrt.sv
design/rtrm_cordic.sv
design/relative_tilt_and_rate_magnitude_top.sv
bench/tb_top.sv
